// ===== hw/rtl/websocket_frame_deframer_macros.svh =====
// assertion macros shared by the websocket deframer rtl
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_SAME(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("websocket deframer assertion failed");

// next-cycle implication, disabled while reset is asserted
`define WSFD_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("websocket deframer assertion failed");

`endif

// ===== hw/rtl/wsfd_pkg.sv =====
// types and constants of the websocket frame deframer
`default_nettype none

package wsfd_pkg;

    localparam int LenW = 63;

    localparam logic [6:0] LEN_CODE_16 = 7'd126;
    localparam logic [6:0] LEN_CODE_64 = 7'd127;
    localparam logic [3:0] OP_MAX_DATA = 4'h2;
    localparam logic [3:0] OP_MIN_CTRL = 4'h8;
    localparam logic [3:0] OP_MAX_CTRL = 4'hA;

    typedef enum logic [2:0] {
        PH_HDR0  = 3'd0,
        PH_HDR1  = 3'd1,
        PH_EXT16 = 3'd2,
        PH_EXT64 = 3'd3,
        PH_KEY   = 3'd4,
        PH_PAY   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        EV_PAYLOAD    = 2'd0,
        EV_EMPTY      = 2'd1,
        EV_BAD_OPCODE = 2'd2,
        EV_OVERSIZE   = 2'd3
    } event_t;

    typedef struct packed {
        logic              emit;
        event_t            ev;
        logic [7:0]        payload;
        logic              last;
        logic              fin;
        logic [2:0]        rsv;
        logic [3:0]        opcode;
        logic              masked;
        logic [LenW-1:0]   len;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/websocket_frame_deframer.sv =====
// websocket frame deframer top level: input handshake and result register
//
// usage:
//   input channel in_valid/in_ready carries one raw stream byte per transaction
//   output channel out_valid/out_ready carries one event per transaction:
//   payload byte (unmasked, last flags the final one), empty frame complete,
//   bad opcode error or oversize length error, with the frame header fields
//   a byte that produces an event shows it on the output in the cycle after acceptance
//   throughput: one byte per cycle while in_ready holds; header, length and key bytes give no event
//   the result register sits behind the parser state, so a byte is
//   taken while the previous result is handed over in the same cycle
//   when the receiver stalls with a result pending, in_ready drops until that
//   result is taken; no byte is lost or dropped
//   reset clears the parser to the first header byte and empties the output
//   after an error event the next byte is parsed as a new frame header
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module websocket_frame_deframer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire logic [7:0]                stream_byte,
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      logic [1:0]                event_res,
    output      logic [7:0]                payload_byte,
    output      logic                      last,
    output      logic                      fin,
    output      logic [2:0]                rsv_bits,
    output      logic [3:0]                opcode,
    output      logic                      masked,
    output      logic [wsfd_pkg::LenW-1:0] payload_length
);
    import wsfd_pkg::*;

    result_t res;
    result_t out_res_reg;
    logic    out_valid_reg, out_valid_next;
    logic    in_accept;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    wsfd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (in_accept),
        .stream_byte (stream_byte),
        .res         (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = res.emit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && res.emit)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_res_reg.ev;
    assign payload_byte   = out_res_reg.payload;
    assign last           = out_res_reg.last;
    assign fin            = out_res_reg.fin;
    assign rsv_bits       = out_res_reg.rsv;
    assign opcode         = out_res_reg.opcode;
    assign masked         = out_res_reg.masked;
    assign payload_length = out_res_reg.len;

    `WSFD_ASSERT_SAME(a_event_no_data, clk, rst_n,
        out_valid_reg && event_res != EV_PAYLOAD, payload_byte == 8'd0 && last == 1'b0)
    `WSFD_ASSERT_SAME(a_error_no_len, clk, rst_n,
        out_valid_reg && (event_res == EV_BAD_OPCODE || event_res == EV_OVERSIZE),
        payload_length == '0)
    `WSFD_ASSERT_NEXT(a_silent_byte, clk, rst_n, in_accept && !res.emit, !out_valid_reg)

endmodule

`default_nettype wire

// ===== hw/rtl/wsfd_parser.sv =====
// byte-serial frame parser: header, extended length, key and payload unmasking
`default_nettype none
`include "websocket_frame_deframer_macros.svh"

module wsfd_parser (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       stream_byte,
    output wsfd_pkg::result_t     res
);
    import wsfd_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [2:0]        fbc_reg, fbc_next;
    logic [8:0]        hb_reg, hb_next;
    logic [63:0]       lr_reg, lr_next;
    logic [LenW-1:0]   br_reg, br_next;
    logic [31:0]       key_reg, key_next;
    logic [1:0]        ki_reg, ki_next;

    logic [63:0]       lr_val;
    logic              len_done;
    logic [3:0]        op;
    logic [6:0]        code;
    logic [2:0]        fbc_limit;
    logic [7:0]        kb;

    always_comb
    begin
        phase_next = phase_reg;
        fbc_next   = fbc_reg;
        hb_next    = hb_reg;
        lr_next    = lr_reg;
        br_next    = br_reg;
        key_next   = key_reg;
        ki_next    = ki_reg;
        lr_val     = lr_reg;
        len_done   = 1'b0;
        op         = hb_reg[4:1];
        code       = stream_byte[6:0];
        fbc_limit  = (phase_reg == PH_EXT16) ? 3'd1 : 3'd7;
        kb         = 8'd0;
        res        = '0;

        unique case (phase_reg)
            PH_HDR1:
            begin
                hb_next  = {hb_reg[8:1], stream_byte[7]};
                key_next = 32'd0;
                if (!(op <= OP_MAX_DATA || (op >= OP_MIN_CTRL && op <= OP_MAX_CTRL)))
                begin
                    phase_next = PH_HDR0;
                    res.emit   = 1'b1;
                    res.ev     = EV_BAD_OPCODE;
                end
                else
                begin
                    lr_next  = 64'd0;
                    fbc_next = 3'd0;
                    if (code == LEN_CODE_16)
                    begin
                        phase_next = PH_EXT16;
                    end
                    else if (code == LEN_CODE_64)
                    begin
                        phase_next = PH_EXT64;
                    end
                    else
                    begin
                        lr_val   = {57'd0, code};
                        lr_next  = lr_val;
                        len_done = 1'b1;
                    end
                end
            end
            PH_EXT16, PH_EXT64:
            begin
                lr_val  = {lr_reg[55:0], stream_byte};
                lr_next = lr_val;
                if (fbc_reg < fbc_limit)
                begin
                    fbc_next = fbc_reg + 3'd1;
                end
                else
                begin
                    fbc_next = 3'd0;
                    if (lr_val[63])
                    begin
                        phase_next = PH_HDR0;
                        res.emit   = 1'b1;
                        res.ev     = EV_OVERSIZE;
                    end
                    else
                    begin
                        len_done = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], stream_byte};
                if (fbc_reg < 3'd3)
                begin
                    fbc_next = fbc_reg + 3'd1;
                end
                else
                begin
                    fbc_next = 3'd0;
                    ki_next  = 2'd0;
                    if (br_reg == '0)
                    begin
                        phase_next = PH_HDR0;
                        res.emit   = 1'b1;
                        res.ev     = EV_EMPTY;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
            end
            PH_PAY:
            begin
                unique case (ki_reg)
                    2'd0:    kb = key_reg[31:24];
                    2'd1:    kb = key_reg[23:16];
                    2'd2:    kb = key_reg[15:8];
                    default: kb = key_reg[7:0];
                endcase
                ki_next     = ki_reg + 2'd1;
                br_next     = br_reg - {{(LenW-1){1'b0}}, 1'b1};
                res.emit    = 1'b1;
                res.ev      = EV_PAYLOAD;
                res.payload = stream_byte ^ kb;
                res.len     = lr_reg[LenW-1:0];
                if (br_reg == {{(LenW-1){1'b0}}, 1'b1})
                begin
                    phase_next = PH_HDR0;
                    res.last   = 1'b1;
                end
            end
            default:
            begin
                // first header byte, also taken for unused phase codes
                hb_next    = {stream_byte, 1'b0};
                phase_next = PH_HDR1;
            end
        endcase

        if (len_done)
        begin
            br_next  = lr_val[LenW-1:0];
            ki_next  = 2'd0;
            fbc_next = 3'd0;
            if (hb_next[0])
            begin
                phase_next = PH_KEY;
            end
            else if (lr_val[LenW-1:0] == '0)
            begin
                phase_next = PH_HDR0;
                res.emit   = 1'b1;
                res.ev     = EV_EMPTY;
            end
            else
            begin
                phase_next = PH_PAY;
            end
        end

        res.fin    = hb_next[8];
        res.rsv    = hb_next[7:5];
        res.opcode = hb_next[4:1];
        res.masked = hb_next[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HDR0;
            fbc_reg   <= 3'd0;
            hb_reg    <= 9'd0;
            lr_reg    <= 64'd0;
            br_reg    <= '0;
            key_reg   <= 32'd0;
            ki_reg    <= 2'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            fbc_reg   <= fbc_next;
            hb_reg    <= hb_next;
            lr_reg    <= lr_next;
            br_reg    <= br_next;
            key_reg   <= key_next;
            ki_reg    <= ki_next;
        end
    end

    `WSFD_ASSERT_SAME(a_pay_has_bytes, clk, rst_n, phase_reg == PH_PAY, br_reg != '0)
    `WSFD_ASSERT_SAME(a_ext16_count, clk, rst_n, phase_reg == PH_EXT16, fbc_reg <= 3'd1)
    `WSFD_ASSERT_NEXT(a_last_to_hdr, clk, rst_n,
        step && phase_reg == PH_PAY && br_reg == {{(LenW-1){1'b0}}, 1'b1},
        phase_reg == PH_HDR0)

endmodule

`default_nettype wire

// ===== tb/websocket_frame_deframer_test.sv =====
// self-checking testbench for the websocket frame deframer
`timescale 1ns / 100ps

module websocket_frame_deframer_test;
    import wsfd_pkg::*;

    localparam int DirRows    = 25;
    localparam int RandItems  = 400;
    localparam int PauseAt    = 330;
    localparam int CalmFrom   = 200;
    localparam int CalmTo     = 300;
    localparam int HoldFrom   = 150;
    localparam int HoldCycles = 80;
    localparam int SteadyFrom = 450;
    localparam int SteadyTo   = 750;
    localparam int CycleLimit = 60000;

    typedef struct packed {
        event_t          ev;
        logic [7:0]      data;
        logic            last;
        logic            fin;
        logic [2:0]      rsv;
        logic [3:0]      opcode;
        logic            masked;
        logic [LenW-1:0] len;
    } frame_event_t;

    typedef struct packed {
        logic [7:0]   data;
        logic         pinned;
        frame_event_t want;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [7:0]          stream_byte;
    logic                out_valid;
    logic                out_ready;
    logic [1:0]          event_res;
    logic [7:0]          payload_byte;
    logic                last;
    logic                fin;
    logic [2:0]          rsv_bits;
    logic [3:0]          opcode;
    logic                masked;
    logic [LenW-1:0]     payload_length;

    // parser state mirrored by the predictor
    phase_t              parse_phase;
    logic [2:0]          field_cnt;
    logic [8:0]          hdr_bits;
    logic [63:0]         len_acc;
    logic [LenW-1:0]     bytes_left;
    logic [31:0]         key_word;
    logic [1:0]          key_pos;

    frame_event_t        events_due[$];
    frame_event_t        seen_event;
    logic                produced;
    logic                drained;
    int                  bytes_sent;
    int                  mismatches;
    int                  cycle_count;
    int                  rx_cycle;
    int                  pick;

    // pinned rows carry a result that can be read straight off the header
    stim_row_t directed_rows [DirRows] = '{
        // empty unmasked ping
        '{8'h89, 1'b0, '0},
        '{8'h00, 1'b1, '{EV_EMPTY, 8'h00, 1'b0, 1'b1, 3'd0, 4'h9, 1'b0, 63'd0}},
        // reserved opcode with every rsv bit set
        '{8'hF3, 1'b0, '0},
        '{8'hFF, 1'b1, '{EV_BAD_OPCODE, 8'h00, 1'b0, 1'b1, 3'd7, 4'h3, 1'b1, 63'd0}},
        // empty masked pong, completes after the last key byte
        '{8'h0A, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{EV_EMPTY, 8'h00, 1'b0, 1'b0, 3'd0, 4'hA, 1'b1, 63'd0}},
        // one unmasked byte behind a non-minimal 16-bit length
        '{8'h82, 1'b0, '0},
        '{8'h7E, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b1, '{EV_PAYLOAD, 8'hFF, 1'b1, 1'b1, 3'd0, 4'h2, 1'b0, 63'd1}},
        // 64-bit length with the top bit set
        '{8'h01, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hFF, 1'b1, '{EV_OVERSIZE, 8'h00, 1'b0, 1'b0, 3'd0, 4'h1, 1'b1, 63'd0}}
    };

    websocket_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .stream_byte    (stream_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .event_res      (event_res),
        .payload_byte   (payload_byte),
        .last           (last),
        .fin            (fin),
        .rsv_bits       (rsv_bits),
        .opcode         (opcode),
        .masked         (masked),
        .payload_length (payload_length)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic frame_event_t make_event(input event_t ev, input logic [7:0] data,
                                                input logic lst, input logic [LenW-1:0] len);
        frame_event_t r;
        r.ev     = ev;
        r.data   = data;
        r.last   = lst;
        r.fin    = hdr_bits[8];
        r.rsv    = hdr_bits[7:5];
        r.opcode = hdr_bits[4:1];
        r.masked = hdr_bits[0];
        r.len    = len;
        return r;
    endfunction

    function automatic logic length_known(output frame_event_t r);
        bytes_left = len_acc[LenW-1:0];
        key_pos    = 2'd0;
        field_cnt  = 3'd0;
        r          = '0;
        if (hdr_bits[0])
        begin
            parse_phase = PH_KEY;
            return 1'b0;
        end
        if (bytes_left == '0)
        begin
            parse_phase = PH_HDR0;
            r = make_event(EV_EMPTY, 8'h00, 1'b0, '0);
            return 1'b1;
        end
        parse_phase = PH_PAY;
        return 1'b0;
    endfunction

    // advances the parser by one stream byte, returns 1 when it yields an event
    function automatic logic parse_byte(input logic [7:0] b, output frame_event_t r);
        logic [3:0] op;
        logic [7:0] kb;
        r = '0;
        case (parse_phase)
            PH_HDR1:
            begin
                hdr_bits[0] = b[7];
                key_word    = '0;
                op          = hdr_bits[4:1];
                if (!(op <= OP_MAX_DATA || (op >= OP_MIN_CTRL && op <= OP_MAX_CTRL)))
                begin
                    parse_phase = PH_HDR0;
                    r = make_event(EV_BAD_OPCODE, 8'h00, 1'b0, '0);
                    return 1'b1;
                end
                len_acc   = '0;
                field_cnt = 3'd0;
                if (b[6:0] == LEN_CODE_16)
                begin
                    parse_phase = PH_EXT16;
                    return 1'b0;
                end
                if (b[6:0] == LEN_CODE_64)
                begin
                    parse_phase = PH_EXT64;
                    return 1'b0;
                end
                len_acc = {57'd0, b[6:0]};
                return length_known(r);
            end
            PH_EXT16, PH_EXT64:
            begin
                len_acc = {len_acc[55:0], b};
                if (field_cnt < ((parse_phase == PH_EXT16) ? 3'd1 : 3'd7))
                begin
                    field_cnt = field_cnt + 3'd1;
                    return 1'b0;
                end
                field_cnt = 3'd0;
                if (len_acc[63])
                begin
                    parse_phase = PH_HDR0;
                    r = make_event(EV_OVERSIZE, 8'h00, 1'b0, '0);
                    return 1'b1;
                end
                return length_known(r);
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                if (field_cnt < 3'd3)
                begin
                    field_cnt = field_cnt + 3'd1;
                    return 1'b0;
                end
                field_cnt = 3'd0;
                key_pos   = 2'd0;
                if (bytes_left == '0)
                begin
                    parse_phase = PH_HDR0;
                    r = make_event(EV_EMPTY, 8'h00, 1'b0, '0);
                    return 1'b1;
                end
                parse_phase = PH_PAY;
                return 1'b0;
            end
            PH_PAY:
            begin
                kb         = key_word[8 * (3 - key_pos) +: 8];
                key_pos    = key_pos + 2'd1;
                bytes_left = bytes_left - 1'b1;
                if (bytes_left == '0)
                begin
                    parse_phase = PH_HDR0;
                    r = make_event(EV_PAYLOAD, b ^ kb, 1'b1, len_acc[LenW-1:0]);
                    return 1'b1;
                end
                r = make_event(EV_PAYLOAD, b ^ kb, 1'b0, len_acc[LenW-1:0]);
                return 1'b1;
            end
            default:
            begin
                hdr_bits    = {b, 1'b0};
                parse_phase = PH_HDR1;
                return 1'b0;
            end
        endcase
    endfunction

    // first header byte with random fin and rsv, opcode legal or reserved
    function automatic logic [7:0] random_header(input logic good);
        logic [3:0] op;
        if (good)
        begin
            op = 4'($urandom_range(0, 5));
            if (op > OP_MAX_DATA)
                op = op + 4'd5;
        end
        else
        begin
            op = 4'($urandom_range(3, 12));
            if (op >= OP_MIN_CTRL)
                op = op + 4'd3;
        end
        return {4'($urandom), op};
    endfunction

    task automatic send_byte(input logic [7:0] b);
        frame_event_t ev;
        if ((bytes_sent < CalmFrom || bytes_sent >= CalmTo) && $urandom_range(0, 99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        stream_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
        produced = parse_byte(b, ev);
        if (produced)
            events_due.push_back(ev);
    endtask

    // sends at most limit bytes of a frame, payload content random
    task automatic send_frame(input logic [7:0] hdr0, input logic mask_bit,
                              input logic [6:0] code, input logic [LenW-1:0] len,
                              input int limit);
        logic [7:0]      frame_bytes[$];
        logic [31:0]     mkey;
        logic [63:0]     len_field;
        logic [LenW-1:0] n;
        mkey        = mask_bit ? $urandom : 32'd0;
        len_field   = {1'b0, len};
        frame_bytes = {hdr0, {mask_bit, code}};
        if (code == LEN_CODE_16)
            for (int i = 1; i >= 0; i--)
                frame_bytes.push_back(len_field[8 * i +: 8]);
        else if (code == LEN_CODE_64)
            for (int i = 7; i >= 0; i--)
                frame_bytes.push_back(len_field[8 * i +: 8]);
        if (mask_bit)
            for (int i = 3; i >= 0; i--)
                frame_bytes.push_back(mkey[8 * i +: 8]);
        n = '0;
        while (frame_bytes.size() < limit && n < len)
        begin
            frame_bytes.push_back(8'($urandom));
            n++;
        end
        while (frame_bytes.size() > limit)
            void'(frame_bytes.pop_back());
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
    endtask

    task automatic send_random_frame(input int limit);
        logic [LenW-1:0] len;
        logic [6:0]      code;
        int              form;
        len  = ($urandom_range(0, 99) < 85) ? LenW'($urandom_range(0, 12))
                                            : LenW'($urandom_range(13, 255));
        form = $urandom_range(0, 9);
        if (len <= 125 && form < 6)
            code = len[6:0];
        else if (form < 8)
            code = LEN_CODE_16;
        else
            code = LEN_CODE_64;
        send_frame(random_header(1'b1), 1'($urandom), code, len, limit);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (events_due.size() == 0)
            begin
                $error("result transaction with no expected event pending");
                mismatches++;
            end
            else
            begin
                seen_event = events_due.pop_front();
                check_field("event_res", 64'(seen_event.ev), 64'(event_res));
                check_field("payload_byte", 64'(seen_event.data), 64'(payload_byte));
                check_field("last", 64'(seen_event.last), 64'(last));
                check_field("fin", 64'(seen_event.fin), 64'(fin));
                check_field("rsv_bits", 64'(seen_event.rsv), 64'(rsv_bits));
                check_field("opcode", 64'(seen_event.opcode), 64'(opcode));
                check_field("masked", 64'(seen_event.masked), 64'(masked));
                check_field("payload_length", 64'(seen_event.len), 64'(payload_length));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CycleLimit)
        begin
            $display("websocket_frame_deframer_test failed");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off and one steady stretch
    initial
    begin
        out_ready <= 1'b0;
        rx_cycle = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= HoldFrom && rx_cycle < HoldFrom + HoldCycles)
                out_ready <= 1'b0;
            else if (rx_cycle >= SteadyFrom && rx_cycle < SteadyTo)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 15);
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    <= 1'b0;
        stream_byte <= 8'h00;
        parse_phase = PH_HDR0;
        field_cnt   = '0;
        hdr_bits    = '0;
        len_acc     = '0;
        bytes_left  = '0;
        key_word    = '0;
        key_pos     = '0;
        drained     = 1'b0;
        bytes_sent  = 0;
        mismatches  = 0;
        cycle_count = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].data);
            if (directed_rows[i].pinned)
                events_due[events_due.size() - 1] = directed_rows[i].want;
        end

        while (bytes_sent < DirRows + RandItems)
        begin
            if (!drained && bytes_sent >= PauseAt && events_due.size() != 0)
            begin
                // let the pipeline drain completely
                drained = 1'b1;
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (events_due.size() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_random_frame(1 << 30);
            else if (pick < 80)
            begin
                send_byte(random_header(1'b0));
                send_byte(8'($urandom));
            end
            else if (pick < 88)
            begin
                send_byte(random_header(1'b1));
                send_byte({1'($urandom), LEN_CODE_64});
                send_byte({1'b1, 7'($urandom)});
                repeat (7) send_byte(8'($urandom));
            end
            else
            begin
                // cut frame, then whatever bytes bring the parser back to a header
                send_random_frame($urandom_range(1, 12));
                while (parse_phase != PH_HDR0)
                begin
                    case (parse_phase)
                        PH_HDR1:           send_byte({1'($urandom), 7'($urandom_range(0, 20))});
                        PH_EXT16, PH_EXT64: send_byte(8'h00);
                        default:           send_byte(8'($urandom));
                    endcase
                end
            end
        end

        // largest legal length, only the first few payload bytes
        send_frame(random_header(1'b1), 1'b1, LEN_CODE_64, {LenW{1'b1}}, 17);

        in_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatches == 0)
            $display("websocket_frame_deframer_test passed");
        else
            $display("websocket_frame_deframer_test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/wsfd_pkg.sv
hw/rtl/wsfd_parser.sv
hw/rtl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_test.sv
